[src/text_console_writer_defines.svh]
// assertion macros for the text console writer
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH
`ifndef ASSERT_OFF
`define TCW_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("text console writer check failed");
`define TCW_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("text console writer check failed");
`else
`define TCW_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TCW_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

[src/tcw_pkg.sv]
// shared constants and control types of the text console writer
`timescale 1ns / 1ps

package tcw_pkg;

   localparam int DEF_SCREEN_COLUMNS = 80;
   localparam int DEF_SCREEN_ROWS    = 25;

   localparam int OPCODE_W     = 2;
   localparam int CHAR_W       = 8;
   localparam int ATTR_W       = 8;
   localparam int CELL_W       = CHAR_W + ATTR_W;
   localparam int CELL_INDEX_W = 11;
   localparam int CURSOR_POS_W = 11;
   localparam int TAB_STEP     = 3;

   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

   localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

   // commands from the controller to the datapath
   typedef struct packed {
      logic req_load;
      logic exec;
      logic scroll_step;
      logic blank_step;
      logic cnt_clr;
      logic cnt_inc;
      logic rsp_load;
   } tcw_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic need_scroll;
      logic op_clear;
      logic copy_end;
      logic cnt_last;
   } tcw_sts_type;

endpackage

[src/tcw_ram.sv]
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/tcw_ctrl.sv]
// controller state machine of the text console writer
`timescale 1ns / 1ps

module tcw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_valid,
   output tcw_pkg::tcw_cmd_type cmd,
   input  tcw_pkg::tcw_sts_type sts
);

   import tcw_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCROLL,
      S_BLANK,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      owed_ff, owed_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      owed_in      = owed_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.req_load = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.need_scroll) begin
               cmd.cnt_clr = 1'b1;
               owed_in     = 1'b1;
               state_in    = S_SCROLL;
            end else if (sts.op_clear) begin
               cmd.cnt_clr = 1'b1;
               owed_in     = 1'b1;
               state_in    = S_BLANK;
            end else begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_SCROLL: begin
            cmd.scroll_step = 1'b1;
            // the counter stays put so the blank pass starts on the bottom row
            if (sts.copy_end) begin
               state_in = S_BLANK;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         S_BLANK: begin
            cmd.blank_step = 1'b1;
            if (sts.cnt_last) begin
               state_in = owed_ff ? S_RESP : S_IDLE;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         S_RESP: begin
            cmd.rsp_load = 1'b1;
            rsp_valid_in = 1'b1;
            owed_in      = 1'b0;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // reset starts with a blanking pass over the whole store
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_BLANK;
         owed_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         owed_ff      <= owed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[src/tcw_datapath.sv]
// datapath of the text console writer: cell store, cursor, sweep counter, result registers
`timescale 1ns / 1ps

module tcw_datapath #(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tcw_pkg::tcw_cmd_type                   cmd,
   output tcw_pkg::tcw_sts_type                   sts,
   input  logic [tcw_pkg::OPCODE_W-1:0]           req_opcode,
   input  logic [tcw_pkg::CHAR_W-1:0]             req_char_code,
   input  logic [tcw_pkg::CELL_INDEX_W-1:0]       req_cell_index,
   input  logic                                   csr_valid,
   input  logic [tcw_pkg::ATTR_W-1:0]             csr_text_attribute,
   output logic [tcw_pkg::CHAR_W-1:0]             rsp_cell_char,
   output logic [tcw_pkg::ATTR_W-1:0]             rsp_cell_attr,
   output logic [tcw_pkg::CURSOR_POS_W-1:0]       rsp_cursor_pos,
   output logic                                   rsp_scrolled
);

   import tcw_pkg::*;

   localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int COL_W      = $clog2(SCREEN_COLUMNS + TAB_STEP);
   localparam int COPY_CNT   = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;
   localparam int CMP_W      = (ADDR_W + 1 > CELL_INDEX_W) ? ADDR_W + 1 : CELL_INDEX_W;

   logic [ATTR_W-1:0]       attr_ff, attr_in;
   logic [ATTR_W-1:0]       fill_attr_ff, fill_attr_in;
   logic [OPCODE_W-1:0]     op_ff, op_in;
   logic [CHAR_W-1:0]       ch_ff, ch_in;
   logic                    inrange_ff, inrange_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ADDR_W-1:0]       base_ff, base_in;
   logic                    scr_ff, scr_in;
   logic [ADDR_W-1:0]       cnt_ff, cnt_in;
   logic [CHAR_W-1:0]       rsp_char_ff, rsp_char_in;
   logic [ATTR_W-1:0]       rsp_attr_ff, rsp_attr_in;
   logic [CURSOR_POS_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic                    rsp_scr_ff, rsp_scr_in;

   logic [CMP_W-1:0]  idx_ext;
   logic              idx_ok;
   logic [ADDR_W-1:0] idx_addr;
   logic              is_put, is_tab, is_nl, is_plain;
   logic [COL_W-1:0]  col_step, col_adv;
   logic              wrap, last_row, need_scroll;
   logic [CMP_W-1:0]  pos_ext;
   logic              show;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [CELL_W-1:0] wr_data, rd_data;

   // read index check and address for a cell read
   assign idx_ext  = CMP_W'(req_cell_index);
   assign idx_ok   = idx_ext < CMP_W'(CELL_COUNT);
   assign idx_addr = idx_ok ? idx_ext[ADDR_W-1:0] : '0;

   // put character decode
   assign is_put      = (op_ff == OP_PUT);
   assign is_tab      = (ch_ff == CH_TAB);
   assign is_nl       = (ch_ff == CH_LF) || (ch_ff == CH_CR);
   assign is_plain    = !is_tab && !is_nl;
   assign col_step    = is_tab ? COL_W'(TAB_STEP) : COL_W'(1);
   assign col_adv     = col_ff + col_step;
   assign wrap        = is_nl || (col_adv >= COL_W'(SCREEN_COLUMNS));
   assign last_row    = (base_ff == ADDR_W'(COPY_CNT));
   assign need_scroll = is_put && wrap && last_row;

   assign sts.need_scroll = need_scroll;
   assign sts.op_clear    = (op_ff == OP_CLEAR);
   assign sts.copy_end    = (cnt_ff == ADDR_W'(COPY_CNT));
   assign sts.cnt_last    = (cnt_ff == ADDR_W'(CELL_COUNT - 1));

   always_comb begin
      col_in  = col_ff;
      base_in = base_ff;
      scr_in  = scr_ff;
      if (cmd.exec) begin
         scr_in = need_scroll;
         if (is_put) begin
            if (wrap) begin
               col_in = '0;
               // on the last row the cursor stays and the store scrolls
               if (!last_row) begin
                  base_in = base_ff + ADDR_W'(SCREEN_COLUMNS);
               end
            end else begin
               col_in = col_adv;
            end
         end else if (op_ff == OP_CLEAR) begin
            col_in  = '0;
            base_in = '0;
         end
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + ADDR_W'(1);
      end
   end

   // one write port shared by character writes, row copies and blanking
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = base_ff + ADDR_W'(col_ff);
      wr_data = {attr_ff, ch_ff};
      if (cmd.exec && is_put && is_plain) begin
         wr_en = 1'b1;
      end else if (cmd.scroll_step && (cnt_ff != '0)) begin
         // copy lands one row up, in the cycle after its read
         wr_en   = 1'b1;
         wr_addr = cnt_ff - ADDR_W'(1);
         wr_data = rd_data;
      end else if (cmd.blank_step) begin
         wr_en   = 1'b1;
         wr_addr = cnt_ff;
         wr_data = {fill_attr_ff, CHAR_W'(0)};
      end
   end

   assign rd_addr = (cmd.scroll_step && !sts.copy_end) ?
                    cnt_ff + ADDR_W'(SCREEN_COLUMNS) : idx_addr;

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_cells (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign attr_in      = csr_valid ? csr_text_attribute : attr_ff;
   assign fill_attr_in = cmd.req_load ? attr_ff : fill_attr_ff;
   assign op_in        = cmd.req_load ? req_opcode : op_ff;
   assign ch_in        = cmd.req_load ? req_char_code : ch_ff;
   assign inrange_in   = cmd.req_load ? idx_ok : inrange_ff;

   assign pos_ext = CMP_W'(base_in) + CMP_W'(col_in);
   assign show    = (op_ff == OP_READ) && inrange_ff;

   assign rsp_char_in = cmd.rsp_load ? (show ? rd_data[CHAR_W-1:0] : '0) : rsp_char_ff;
   assign rsp_attr_in = cmd.rsp_load ? (show ? rd_data[CELL_W-1:CHAR_W] : '0) : rsp_attr_ff;
   assign rsp_pos_in  = cmd.rsp_load ? pos_ext[CURSOR_POS_W-1:0] : rsp_pos_ff;
   assign rsp_scr_in  = cmd.rsp_load ? scr_in : rsp_scr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= RESET_ATTR;
         fill_attr_ff <= RESET_ATTR;
         col_ff       <= '0;
         base_ff      <= '0;
         scr_ff       <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         attr_ff      <= attr_in;
         fill_attr_ff <= fill_attr_in;
         col_ff       <= col_in;
         base_ff      <= base_in;
         scr_ff       <= scr_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      ch_ff       <= ch_in;
      inrange_ff  <= inrange_in;
      rsp_char_ff <= rsp_char_in;
      rsp_attr_ff <= rsp_attr_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_scr_ff  <= rsp_scr_in;
   end

   assign rsp_cell_char  = rsp_char_ff;
   assign rsp_cell_attr  = rsp_attr_ff;
   assign rsp_cursor_pos = rsp_pos_ff;
   assign rsp_scrolled   = rsp_scr_ff;

endmodule

[src/text_console_writer.sv]
// top level of the text console writer
`timescale 1ns / 1ps
`include "text_console_writer_defines.svh"

// Text console writer: a SCREEN_COLUMNS x SCREEN_ROWS cell store with a cursor.
// Request: a transfer happens at a rising edge with start high and busy low;
// req_opcode selects put character, read cell or clear screen.
// Result: one per request, held on the rsp_ ports for exactly one cycle with
// rsp_valid high; the receiver cannot stall it.
// Put character, read cell and the unused opcode pass through the accept
// cycle and the execute cycle, in which the cell store is written or its
// registered read data is taken. The result shows in the cycle after that,
// while the next request may already be accepted.
// A put character that scrolls runs a copy pass and then a blanking pass: the
// single write port of the store copies one cell per cycle, then blanks the
// bottom row one cell per cycle.
// Clear screen blanks the whole store, one cell a cycle.
// Reset blanks the store with attribute 7 in a pass over all
// SCREEN_COLUMNS*SCREEN_ROWS cells (2000 at 80x25) with busy high; csr
// writes of the text attribute are taken at any time (csr_ready is always high)
// and should be made while no request is in flight.

module text_console_writer #(
   parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
   parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [tcw_pkg::OPCODE_W-1:0]     req_opcode,
   input  logic [tcw_pkg::CHAR_W-1:0]       req_char_code,
   input  logic [tcw_pkg::CELL_INDEX_W-1:0] req_cell_index,
   output logic                             rsp_valid,
   output logic [tcw_pkg::CHAR_W-1:0]       rsp_cell_char,
   output logic [tcw_pkg::ATTR_W-1:0]       rsp_cell_attr,
   output logic [tcw_pkg::CURSOR_POS_W-1:0] rsp_cursor_pos,
   output logic                             rsp_scrolled,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tcw_pkg::ATTR_W-1:0]       csr_text_attribute
);

   import tcw_pkg::*;

   tcw_cmd_type cmd;
   tcw_sts_type sts;

   assign csr_ready = 1'b1;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   tcw_datapath #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_opcode         (req_opcode),
      .req_char_code      (req_char_code),
      .req_cell_index     (req_cell_index),
      .csr_valid          (csr_valid),
      .csr_text_attribute (csr_text_attribute),
      .rsp_cell_char      (rsp_cell_char),
      .rsp_cell_attr      (rsp_cell_attr),
      .rsp_cursor_pos     (rsp_cursor_pos),
      .rsp_scrolled       (rsp_scrolled)
   );

   // results never come in consecutive cycles
   `TCW_ASSERT_NXT(a_rsp_gap, clock, reset, rsp_valid, !rsp_valid)
   // an accepted request always moves the controller out of idle
   `TCW_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy)
   // only a put character scrolls, so no cell data rides with a scroll
   `TCW_ASSERT_IMP(a_scroll_no_cell, clock, reset, rsp_valid && rsp_scrolled,
                   rsp_cell_char == '0 && rsp_cell_attr == '0)
   // copy and blank passes never drive the write port together
   `TCW_ASSERT_IMP(a_sweep_excl, clock, reset, cmd.scroll_step, !cmd.blank_step && !cmd.exec)

endmodule

[dv/tb_top.sv]
// self-checking testbench for the text console writer: directed table, random text, csr phases
`timescale 1ns / 1ps

module tb_top;
   import tcw_pkg::*;

   localparam int COLS  = DEF_SCREEN_COLUMNS;
   localparam int ROWS  = DEF_SCREEN_ROWS;
   localparam int CELLS = COLS * ROWS;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   localparam int SCROLL_BUDGET = 150;
   localparam int CLEAR_BUDGET  = 25;
   localparam int PHASE_COUNT   = 8;
   localparam int PHASE_ITEMS   = 250;
   localparam int CYCLE_LIMIT   = 2_000_000;

   typedef struct packed {
      logic [CHAR_W-1:0]       ch;
      logic [ATTR_W-1:0]       attr;
      logic [CURSOR_POS_W-1:0] pos;
      logic                    scrolled;
   } console_rsp_type;

   typedef struct packed {
      logic [OPCODE_W-1:0]     op;
      logic [CHAR_W-1:0]       ch;
      logic [CELL_INDEX_W-1:0] idx;
      logic                    typed;
      console_rsp_type         want;
   } stim_row_type;

   // typed rows come straight from the reset state and simple cursor arithmetic
   localparam stim_row_type DIRECTED [0:22] = '{
      '{OP_READ,   8'h00, 11'd0,    1'b1, '{8'h00, 8'h07, 11'd0,   1'b0}},
      '{OP_READ,   8'h00, 11'd1999, 1'b1, '{8'h00, 8'h07, 11'd0,   1'b0}},
      '{OP_READ,   8'h00, 11'd2000, 1'b1, '{8'h00, 8'h00, 11'd0,   1'b0}},
      '{OP_READ,   8'hFF, 11'd2047, 1'b1, '{8'h00, 8'h00, 11'd0,   1'b0}},
      '{OP_UNUSED, 8'hFF, 11'd2047, 1'b1, '{8'h00, 8'h00, 11'd0,   1'b0}},
      '{OP_PUT,    8'h41, 11'd0,    1'b1, '{8'h00, 8'h00, 11'd1,   1'b0}},
      '{OP_PUT,    8'hFF, 11'd2047, 1'b1, '{8'h00, 8'h00, 11'd2,   1'b0}},
      '{OP_PUT,    8'h00, 11'd0,    1'b1, '{8'h00, 8'h00, 11'd3,   1'b0}},
      '{OP_PUT,    CH_TAB, 11'd0,   1'b1, '{8'h00, 8'h00, 11'd6,   1'b0}},
      '{OP_PUT,    CH_LF, 11'd0,    1'b1, '{8'h00, 8'h00, 11'd80,  1'b0}},
      '{OP_PUT,    CH_CR, 11'd0,    1'b1, '{8'h00, 8'h00, 11'd160, 1'b0}},
      '{OP_PUT,    8'h80, 11'd0,    1'b1, '{8'h00, 8'h00, 11'd161, 1'b0}},
      '{OP_READ,   8'h00, 11'd0,    1'b1, '{8'h41, 8'h07, 11'd161, 1'b0}},
      '{OP_READ,   8'h00, 11'd1,    1'b1, '{8'hFF, 8'h07, 11'd161, 1'b0}},
      '{OP_READ,   8'h00, 11'd2,    1'b1, '{8'h00, 8'h07, 11'd161, 1'b0}},
      '{OP_READ,   8'h00, 11'd160,  1'b1, '{8'h80, 8'h07, 11'd161, 1'b0}},
      '{OP_READ,   8'h00, 11'd3,    1'b1, '{8'h00, 8'h07, 11'd161, 1'b0}},
      '{OP_CLEAR,  8'hFF, 11'd2047, 1'b1, '{8'h00, 8'h00, 11'd0,   1'b0}},
      '{OP_READ,   8'h00, 11'd0,    1'b1, '{8'h00, 8'h07, 11'd0,   1'b0}},
      '{OP_READ,   8'h00, 11'd160,  1'b1, '{8'h00, 8'h07, 11'd0,   1'b0}},
      '{OP_PUT,    8'h7E, 11'd0,    1'b0, '0},
      '{OP_PUT,    CH_TAB, 11'd0,   1'b0, '0},
      '{OP_READ,   8'h00, 11'd0,    1'b0, '0}
   };

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [OPCODE_W-1:0]     req_opcode;
   logic [CHAR_W-1:0]       req_char_code;
   logic [CELL_INDEX_W-1:0] req_cell_index;
   logic                    rsp_valid;
   logic [CHAR_W-1:0]       rsp_cell_char;
   logic [ATTR_W-1:0]       rsp_cell_attr;
   logic [CURSOR_POS_W-1:0] rsp_cursor_pos;
   logic                    rsp_scrolled;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [ATTR_W-1:0]       csr_text_attribute;

   // predicted console state
   logic [CELL_W-1:0] cell_model [CELLS];
   int unsigned       cur_col;
   int unsigned       cur_row;
   logic [ATTR_W-1:0] attr_model;

   console_rsp_type pending_rsp [$];
   console_rsp_type mon_want;
   int              failures;
   int              rsp_count;
   int              scroll_total;
   int              clear_total;
   int              cycle_count;

   text_console_writer DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_char_code      (req_char_code),
      .req_cell_index     (req_cell_index),
      .rsp_valid          (rsp_valid),
      .rsp_cell_char      (rsp_cell_char),
      .rsp_cell_attr      (rsp_cell_attr),
      .rsp_cursor_pos     (rsp_cursor_pos),
      .rsp_scrolled       (rsp_scrolled),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_text_attribute (csr_text_attribute)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   task automatic report_mismatch(string msg);
      $display("ERROR: %s", msg);
      failures++;
   endtask

   task automatic check_field(string name, int got, int want);
      if (got != want)
         report_mismatch($sformatf("result %0d %s got %0h want %0h", rsp_count, name, got, want));
   endtask

   function automatic void blank_cells(int first, int count);
      for (int i = first; i < first + count; i++) cell_model[i] = {attr_model, 8'h00};
   endfunction

   // returns 1 when the new line pushed the store up one row
   function automatic logic start_new_line();
      cur_col = 0;
      cur_row++;
      if (cur_row >= ROWS) begin
         for (int i = 0; i < CELLS - COLS; i++) cell_model[i] = cell_model[i + COLS];
         blank_cells(CELLS - COLS, COLS);
         cur_row = ROWS - 1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic put_would_scroll(logic [CHAR_W-1:0] ch);
      if (cur_row != ROWS - 1) return 1'b0;
      if (ch == CH_LF || ch == CH_CR) return 1'b1;
      if (ch == CH_TAB) return (cur_col + TAB_STEP >= COLS);
      return (cur_col + 1 >= COLS);
   endfunction

   function automatic console_rsp_type apply_console_op(logic [OPCODE_W-1:0] op,
                                                        logic [CHAR_W-1:0] ch,
                                                        logic [CELL_INDEX_W-1:0] idx);
      console_rsp_type r;
      r = '0;
      case (op)
         OP_PUT: begin
            if (ch == CH_TAB) begin
               cur_col += TAB_STEP;
               if (cur_col >= COLS) r.scrolled = start_new_line();
            end else if (ch == CH_LF || ch == CH_CR) begin
               r.scrolled = start_new_line();
            end else begin
               cell_model[cur_row * COLS + cur_col] = {attr_model, ch};
               cur_col++;
               if (cur_col >= COLS) r.scrolled = start_new_line();
            end
         end
         OP_READ: begin
            if (idx < CELLS) {r.attr, r.ch} = cell_model[idx];
         end
         OP_CLEAR: begin
            blank_cells(0, CELLS);
            cur_col = 0;
            cur_row = 0;
         end
         default: ;
      endcase
      r.pos = CURSOR_POS_W'(cur_row * COLS + cur_col);
      return r;
   endfunction

   function automatic logic [CELL_INDEX_W-1:0] pick_cell_index();
      if ($urandom_range(0, 9) == 0) return CELL_INDEX_W'($urandom_range(CELLS, 2047));
      return CELL_INDEX_W'($urandom_range(0, CELLS - 1));
   endfunction

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_console_item(logic [OPCODE_W-1:0] op, logic [CHAR_W-1:0] ch,
                                    logic [CELL_INDEX_W-1:0] idx, logic typed,
                                    console_rsp_type want);
      console_rsp_type predicted;
      start          <= 1'b1;
      req_opcode     <= op;
      req_char_code  <= ch;
      req_cell_index <= idx;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = apply_console_op(op, ch, idx);
      if (predicted.scrolled) scroll_total++;
      pending_rsp.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic emit_item(logic [OPCODE_W-1:0] op, logic [CHAR_W-1:0] ch,
                            logic [CELL_INDEX_W-1:0] idx, logic may_idle);
      // scroll and clear each walk the whole store, so their number is capped
      if (op == OP_PUT && put_would_scroll(ch) && scroll_total >= SCROLL_BUDGET) begin
         op  = OP_READ;
         idx = pick_cell_index();
      end
      if (op == OP_CLEAR) begin
         if (clear_total >= CLEAR_BUDGET) op = OP_READ;
         else clear_total++;
      end
      if (may_idle && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      send_console_item(op, ch, idx, 1'b0, '0);
   endtask

   task automatic write_text_attribute(logic [ATTR_W-1:0] value);
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_valid          <= 1'b1;
      csr_text_attribute <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      attr_model = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // lines of random text with tabs, reads and noise mixed in
   task automatic run_text_phase(int n_items, logic allow_idle);
      int   sent;
      int   len;
      int   r;
      logic idle_line;
      sent = 0;
      while (sent < n_items) begin
         idle_line = allow_idle && ($urandom_range(0, 9) < 7);
         len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 20) : $urandom_range(60, 90);
         repeat (len) begin
            r = $urandom_range(0, 99);
            if (r == 0)
               emit_item(OP_UNUSED, CHAR_W'($urandom), CELL_INDEX_W'($urandom), idle_line);
            else if (r == 1)
               emit_item(OP_CLEAR, CHAR_W'($urandom), CELL_INDEX_W'($urandom), idle_line);
            else if (r < 16)
               emit_item(OP_READ, CHAR_W'($urandom), pick_cell_index(), idle_line);
            else if (r < 26)
               emit_item(OP_PUT, CH_TAB, CELL_INDEX_W'($urandom), idle_line);
            else
               emit_item(OP_PUT, CHAR_W'($urandom), CELL_INDEX_W'($urandom), idle_line);
            if (r != 0) sent++;
         end
         // an unterminated line now and then
         r = $urandom_range(0, 9);
         if (r < 9) begin
            emit_item(OP_PUT, (r < 5) ? CH_LF : CH_CR, CELL_INDEX_W'($urandom), idle_line);
            sent++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch($sformatf("result transfer %0d with nothing pending", rsp_count));
         end else begin
            mon_want = pending_rsp.pop_front();
            check_field("cell_char", rsp_cell_char, mon_want.ch);
            check_field("cell_attr", rsp_cell_attr, mon_want.attr);
            check_field("cursor_pos", rsp_cursor_pos, mon_want.pos);
            check_field("scrolled", rsp_scrolled, mon_want.scrolled);
         end
         rsp_count++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("text_console_writer verification failed");
         $finish;
      end
   end

   initial begin
      reset              = 1'b1;
      start              = 1'b0;
      req_opcode         = OP_PUT;
      req_char_code      = '0;
      req_cell_index     = '0;
      csr_valid          = 1'b0;
      csr_text_attribute = '0;
      failures           = 0;
      rsp_count          = 0;
      scroll_total       = 0;
      clear_total        = 0;
      cycle_count        = 0;
      attr_model         = RESET_ATTR;
      cur_col            = 0;
      cur_row            = 0;
      blank_cells(0, CELLS);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i])
         send_console_item(DIRECTED[i].op, DIRECTED[i].ch, DIRECTED[i].idx,
                           DIRECTED[i].typed, DIRECTED[i].want);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p == 0) write_text_attribute(8'h00);
         else if (p == 1) write_text_attribute(8'hFF);
         else write_text_attribute(ATTR_W'($urandom_range(0, 255)));
         // last phase runs back to back
         run_text_phase(PHASE_ITEMS, p != PHASE_COUNT - 1);
      end

      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      while (pending_rsp.size() != 0)
         report_mismatch($sformatf("no result for pending item, cursor %0d",
                                   pending_rsp.pop_front().pos));
      if (failures == 0) begin
         $display("text_console_writer verification clean");
      end else begin
         $display("text_console_writer verification failed");
      end
      $finish;
   end

endmodule
